FILE: src/b64_pkg.sv
// Package for the base64 stream decoder.
// Holds the character constants, the symbol lookup and the state and result types.
// No dependencies.
`default_nettype none
package b64_pkg;

	localparam logic [7:0] CH_PAD = 8'h3D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	localparam logic [6:0] SYM_PAD     = 7'd64;
	localparam logic [6:0] SYM_INVALID = 7'd127;
	localparam logic [5:0] SEXTET_MASK = 6'h3F;

	typedef struct packed {
		logic [23:0] accum;
		logic [1:0]  pos;
		logic [1:0]  pad;
		logic        cr;
		logic        err;
	} dec_state_t;

	typedef struct packed {
		logic        emit;
		logic [23:0] bytes;
		logic [1:0]  count;
		logic        status;
		logic        eom;
	} dec_result_t;

	function automatic logic [6:0] sym_value(input logic [7:0] c);
		logic [6:0] v;
		v = SYM_INVALID;
		if (c >= 8'h41 && c <= 8'h5A) begin
			v = 7'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			v = 7'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			v = 7'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			v = 7'd62;
		end else if (c == 8'h2F) begin
			v = 7'd63;
		end else if (c == CH_PAD) begin
			v = SYM_PAD;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: src/b64_step.sv
// Next-state and result logic for one character of the base64 decoder.
// Purely combinational; uses b64_pkg for types, constants and the symbol lookup.
`default_nettype none
module b64_step (
	input  wire logic [7:0]          ch,
	input  wire logic                last,
	input  wire b64_pkg::dec_state_t cur,
	output b64_pkg::dec_state_t      nxt,
	output b64_pkg::dec_result_t     res
);

	logic [6:0]  v;
	logic [23:0] shifted;

	assign v       = b64_pkg::sym_value(ch);
	assign shifted = {cur.accum[17:0], v[5:0] & b64_pkg::SEXTET_MASK};

	always_comb begin
		nxt        = cur;
		res        = '0;
		if (!cur.err) begin
			if (cur.cr) begin
				nxt.cr = 1'b0;
				if (ch != b64_pkg::CH_LF) begin
					nxt.err = 1'b1;
				end
			end else if (ch == b64_pkg::CH_CR) begin
				nxt.cr = 1'b1;
			end else if (ch != b64_pkg::CH_LF) begin
				if (v == b64_pkg::SYM_PAD) begin
					if (cur.pad >= 2'd2) begin
						nxt.err = 1'b1;
					end else begin
						nxt.pad = cur.pad + 2'd1;
					end
				end else if (v == b64_pkg::SYM_INVALID) begin
					nxt.err = 1'b1;
				end else if (cur.pad != 2'd0) begin
					nxt.err = 1'b1;
				end
				if (!nxt.err) begin
					nxt.pos = cur.pos + 2'd1;
					if (nxt.pos == 2'd0) begin
						res.count = 2'd3 - nxt.pad;
						case (nxt.pad)
							2'd0:    res.bytes = shifted;
							2'd1:    res.bytes = shifted & 24'hFFFF00;
							default: res.bytes = shifted & 24'hFF0000;
						endcase
						res.emit  = 1'b1;
						nxt.accum = '0;
					end else begin
						nxt.accum = shifted;
					end
				end
			end
		end
		if (last) begin
			if (nxt.cr) begin
				nxt.err = 1'b1;
			end
			if (nxt.err) begin
				res.bytes = '0;
				res.count = '0;
			end
			res.status = nxt.err;
			res.eom    = 1'b1;
			res.emit   = 1'b1;
			nxt        = '0;
		end
	end

endmodule
`default_nettype wire

FILE: src/base64_stream_decoder_core.sv
// Base64 stream decoder: one character per item, at most one result per item.
// An accepted character is held in the input register; b64_step decodes it and its result is registered.
// Throughput: one character per cycle while no result is held; a character whose decode step between
// the input register and the result register emits a result waits while the held result is not taken.
// Reset: arst_n clears the decode state and all valid flags at once.
// Depends on b64_pkg and b64_step.
`default_nettype none
module base64_stream_decoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [7:0]  ch,
	input  wire logic        last,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [23:0]      group_bytes,
	output logic [1:0]       byte_count,
	output logic             status,
	output logic             end_of_message
);

	logic                 valid_s1;
	logic [7:0]           ch_s1;
	logic                 last_s1;
	b64_pkg::dec_state_t  state_q;
	b64_pkg::dec_state_t  state_nxt;
	b64_pkg::dec_result_t res;
	logic                 slot_free;
	logic                 advance;

	b64_step u_step (
		.ch   (ch_s1),
		.last (last_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	assign slot_free  = !result_valid || result_ready;
	assign advance    = valid_s1 && (!res.emit || slot_free);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && res.emit) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			group_bytes    <= res.bytes;
			byte_count     <= res.count;
			status         <= res.status;
			end_of_message <= res.eom;
		end
	end

`ifndef NO_ASSERTIONS
	a_err_result_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status |-> end_of_message && byte_count == 2'd0 && group_bytes == 24'd0)
		else $error("failed message result carries data");

	a_mid_result_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !end_of_message |-> byte_count != 2'd0 && !status)
		else $error("group result without bytes or with error");

	a_eom_clears_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> state_q == '0)
		else $error("state not cleared after end of message");
`endif

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for base64_stream_decoder_core.
// Sends directed and random base64 messages through the item handshake, predicts each decoded
// group in a scoreboard class and checks every result. Depends on b64_pkg and the core RTL.
module testbench;

	typedef enum logic [1:0] {K_DATA, K_PAD, K_BAD} char_kind_t;

	typedef struct packed {
		logic [23:0] bytes;
		logic [1:0]  count;
		logic        status;
		logic        eom;
	} group_out_t;

	class b64_group_scoreboard;
		group_out_t pending_groups[$];
		int failures;
		logic [23:0] acc;
		logic [1:0] pos;
		logic [1:0] pads;
		logic cr_wait;
		logic failed;

		function new();
			failures = 0;
			clear_message();
		endfunction

		function void clear_message();
			acc = '0;
			pos = '0;
			pads = '0;
			cr_wait = 1'b0;
			failed = 1'b0;
		endfunction

		function char_kind_t classify(input logic [7:0] c, output logic [5:0] v);
			v = '0;
			if (c >= "A" && c <= "Z") begin
				v = 6'(c - "A");
			end else if (c >= "a" && c <= "z") begin
				v = 6'(c - "a" + 8'd26);
			end else if (c >= "0" && c <= "9") begin
				v = 6'(c - "0" + 8'd52);
			end else if (c == "+") begin
				v = 6'd62;
			end else if (c == "/") begin
				v = 6'd63;
			end else if (c == b64_pkg::CH_PAD) begin
				return K_PAD;
			end else begin
				return K_BAD;
			end
			return K_DATA;
		endfunction

		function void decode_char(input logic [7:0] c, input logic l);
			logic [5:0] v;
			logic [23:0] bytes;
			logic [1:0] count;
			logic emit;
			char_kind_t kind;
			v = '0;
			bytes = '0;
			count = '0;
			emit = 1'b0;
			if (!failed) begin
				if (cr_wait) begin
					cr_wait = 1'b0;
					if (c != b64_pkg::CH_LF)
						failed = 1'b1;
				end else if (c == b64_pkg::CH_CR) begin
					cr_wait = 1'b1;
				end else if (c != b64_pkg::CH_LF) begin
					kind = classify(c, v);
					case (kind)
						K_PAD: begin
							if (pads == 2'd2)
								failed = 1'b1;
							else
								pads = pads + 2'd1;
						end
						K_BAD: failed = 1'b1;
						default: begin
							if (pads != 2'd0)
								failed = 1'b1;
						end
					endcase
					if (!failed) begin
						acc = {acc[17:0], v};
						pos = pos + 2'd1;
						if (pos == 2'd0) begin
							count = 2'd3 - pads;
							case (count)
								2'd3: bytes = acc;
								2'd2: bytes = {acc[23:8], 8'h00};
								default: bytes = {acc[23:16], 16'h0000};
							endcase
							acc = '0;
							emit = 1'b1;
						end
					end
				end
			end
			if (l) begin
				if (cr_wait)
					failed = 1'b1;
				if (failed) begin
					bytes = '0;
					count = '0;
				end
				pending_groups.push_back('{bytes, count, failed, 1'b1});
				clear_message();
			end else if (emit) begin
				pending_groups.push_back('{bytes, count, 1'b0, 1'b0});
			end
		endfunction

		function void report_field(input string name, input logic [23:0] want,
				input logic [23:0] got);
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			failures++;
		endfunction

		function void check_group(input logic [23:0] b, input logic [1:0] n, input logic s,
				input logic e);
			group_out_t want;
			if (pending_groups.size() == 0) begin
				$display("%0t: unexpected result, expected none, got bytes %0h count %0d status %0b eom %0b",
					$time, b, n, s, e);
				failures++;
				return;
			end
			want = pending_groups.pop_front();
			if (b !== want.bytes)
				report_field("group_bytes", want.bytes, b);
			if (n !== want.count)
				report_field("byte_count", 24'(want.count), 24'(n));
			if (s !== want.status)
				report_field("status", 24'(want.status), 24'(s));
			if (e !== want.eom)
				report_field("end_of_message", 24'(want.eom), 24'(e));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic [7:0] ch = '0;
	logic last = 1'b0;
	logic result_ready = 1'b0;
	logic item_ready;
	logic result_valid;
	logic [23:0] group_bytes;
	logic [1:0] byte_count;
	logic status;
	logic end_of_message;

	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	int items_sent = 0;
	int stall_left = 0;
	b64_group_scoreboard sb = new();

	base64_stream_decoder_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.ch            (ch),
		.last          (last),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.group_bytes   (group_bytes),
		.byte_count    (byte_count),
		.status        (status),
		.end_of_message(end_of_message)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready)
			sb.decode_char(ch, last);
		if (arst_n && result_valid && result_ready)
			sb.check_group(group_bytes, byte_count, status, end_of_message);
	end

	always @(negedge clk) begin
		if (stall_left == 0 && stalls_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 9);
		if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	function automatic logic [7:0] alpha_char(input int unsigned idx);
		if (idx < 26)
			return 8'(idx) + "A";
		if (idx < 52)
			return 8'(idx - 26) + "a";
		if (idx < 62)
			return 8'(idx - 52) + "0";
		return (idx == 62) ? "+" : "/";
	endfunction

	task automatic send_char(input logic [7:0] c, input logic l);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		item_valid <= 1'b1;
		ch <= c;
		last <= l;
		do @(posedge clk); while (!item_ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	task automatic send_bytes(input logic [7:0] msg[$]);
		foreach (msg[i])
			send_char(msg[i], i == msg.size() - 1);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending_groups.size() != 0) @(negedge clk);
	endtask

	task automatic send_random_message();
		logic [7:0] msg[$];
		int unsigned shape;
		int unsigned groups;
		int unsigned slot;
		shape = $urandom_range(0, 19);
		if (shape == 0) begin
			repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom_range(0, 255)));
		end else begin
			groups = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 3);
			repeat (groups) begin
				repeat (4) msg.push_back(alpha_char($urandom_range(0, 63)));
				if ($urandom_range(0, 7) == 0) begin
					if ($urandom_range(0, 1) == 1)
						msg.push_back(b64_pkg::CH_CR);
					msg.push_back(b64_pkg::CH_LF);
				end
			end
			case ($urandom_range(0, 5))
				1: begin
					repeat (2) msg.push_back(alpha_char($urandom_range(0, 63)));
					repeat (2) msg.push_back(b64_pkg::CH_PAD);
				end
				2: begin
					repeat (3) msg.push_back(alpha_char($urandom_range(0, 63)));
					msg.push_back(b64_pkg::CH_PAD);
				end
				3: repeat ($urandom_range(1, 3)) msg.push_back(alpha_char($urandom_range(0, 63)));
				default: ;
			endcase
			if (shape <= 4) begin
				slot = $urandom_range(0, msg.size());
				case ($urandom_range(0, 3))
					0: msg.insert(slot, 8'($urandom_range(0, 255)));
					1: msg.insert(slot, b64_pkg::CH_CR);
					2: msg.insert(slot, b64_pkg::CH_PAD);
					default: begin
						msg.push_back(b64_pkg::CH_PAD);
						msg.push_back(alpha_char($urandom_range(0, 63)));
					end
				endcase
			end
			if (msg.size() == 0 || $urandom_range(0, 5) == 0) begin
				if ($urandom_range(0, 1) == 1)
					msg.push_back(b64_pkg::CH_CR);
				msg.push_back(b64_pkg::CH_LF);
			end
		end
		send_bytes(msg);
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_text("+/az\n09AZ\r\nQQ==");
		send_char(8'hFF, 1'b1);
		send_text("===");
		send_text("=A");
		send_text("\rQ");
		send_text("\r");
		send_text("\n");
		send_text("AB");
		wait_drained();

		while (items_sent < 800) begin
			if ($urandom_range(0, 29) == 0)
				wait_drained();
			send_random_message();
			if (items_sent >= 650) begin
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end
		end

		item_valid <= 1'b0;
		while (sb.pending_groups.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (sb.failures == 0)
			$display("base64_stream_decoder_core test passed");
		else
			$display("base64_stream_decoder_core test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("base64_stream_decoder_core test failed");
		$finish;
	end

endmodule
